### src/frame_rotate_flip_point_ops_defines.svh
// Assertion macros for the frame engine top level.
// Each macro takes a label, the clock and (where used) the active-low reset.
`ifndef FRAME_ROTATE_FLIP_POINT_OPS_DEFINES_SVH
`define FRAME_ROTATE_FLIP_POINT_OPS_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define FRFPO_ASSERT(name, clk_s, rstn_s, prop) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("frfpo assertion failed");
// Checked property that also holds during reset.
`define FRFPO_ASSERT_NORST(name, clk_s, prop) \
  name: assert property (@(posedge clk_s) (prop)) \
    else $error("frfpo assertion failed");
`else
`define FRFPO_ASSERT(name, clk_s, rstn_s, prop)
`define FRFPO_ASSERT_NORST(name, clk_s, prop)
`endif

`endif

### src/frfpo_pkg.sv
package frfpo_pkg;

  // Frame store geometry.
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int POS_W       = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);

  // Field widths.
  localparam int DIM_W  = 9;
  localparam int AREA_W = 2 * DIM_W;
  localparam int CH_W   = 8;
  localparam int PIX_W  = 3 * CH_W;
  localparam int SUM_W  = CH_W + 2;
  localparam int OFF_W  = 9;
  localparam int GEO_W  = 3;
  localparam int PT_W   = 2;

  // Read address product and the signed sum used for the brightness clamp.
  localparam int PROD_W = POS_W + DIM_W;
  localparam int BV_W   = CH_W + 3;

  // Configuration port.
  localparam int PADDR_W = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = PADDR_W - 2;

  localparam logic [IDX_W-1:0] REG_GEOMETRY   = 3'd0;
  localparam logic [IDX_W-1:0] REG_POINT      = 3'd1;
  localparam logic [IDX_W-1:0] REG_BRIGHTNESS = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIDTH      = 3'd3;
  localparam logic [IDX_W-1:0] REG_HEIGHT     = 3'd4;

  localparam logic [GEO_W-1:0] GEO_IDENT  = 3'd0;
  localparam logic [GEO_W-1:0] GEO_ROT90  = 3'd1;
  localparam logic [GEO_W-1:0] GEO_ROT180 = 3'd2;
  localparam logic [GEO_W-1:0] GEO_ROT270 = 3'd3;
  localparam logic [GEO_W-1:0] GEO_MIRROR = 3'd4;

  localparam logic [PT_W-1:0] PT_NONE   = 2'd0;
  localparam logic [PT_W-1:0] PT_GRAY   = 2'd1;
  localparam logic [PT_W-1:0] PT_INVERT = 2'd2;
  localparam logic [PT_W-1:0] PT_BRIGHT = 2'd3;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;
  localparam logic [CH_W-1:0]  CH_MAX    = 8'd255;

  // Division by three through a reciprocal; exact for sums up to 3 * 255.
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int DIV3_W     = SUM_W + DIV3_SHIFT;

  typedef struct packed {
    logic            action;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            end_of_row;
    logic            end_of_frame;
    logic            not_ready;
  } out_item_t;

  typedef struct packed {
    logic [GEO_W-1:0]        geometry_mode;
    logic [PT_W-1:0]         point_mode;
    logic signed [OFF_W-1:0] brightness_offset;
    logic [DIM_W-1:0]        image_width;
    logic [DIM_W-1:0]        image_height;
  } cfg_t;

  typedef struct packed {
    logic geom_wr;
    logic dim_wr;
  } cfg_evt_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic not_ready;
    logic end_of_row;
    logic end_of_frame;
  } tag_t;

  // A zero dimension acts as one, an oversized one as the store limit.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > maxv) begin
      res = DIM_W'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] s);
    logic [DIV3_W-1:0] p;
    p = DIV3_W'(s) * DIV3_W'(DIV3_MUL);
    return p[DIV3_SHIFT +: CH_W];
  endfunction

endpackage

### src/frfpo_cfg_regs.sv
module frfpo_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [frfpo_pkg::PADDR_W-1:0]  paddr,
  input  logic [frfpo_pkg::DATA_W-1:0]   pwdata,
  output logic [frfpo_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output frfpo_pkg::cfg_t                cfg,
  output frfpo_pkg::cfg_evt_t            evt
);

  frfpo_pkg::cfg_t               cfg_r;
  frfpo_pkg::cfg_t               cfg_nxt;
  logic                          wr_en;
  logic [frfpo_pkg::IDX_W-1:0]   idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[frfpo_pkg::PADDR_W-1:2];

  always_comb begin
    cfg_nxt     = cfg_r;
    evt.geom_wr = 1'b0;
    evt.dim_wr  = 1'b0;
    if (wr_en) begin
      unique case (idx)
        frfpo_pkg::REG_GEOMETRY: begin
          cfg_nxt.geometry_mode = pwdata[frfpo_pkg::GEO_W-1:0];
          evt.geom_wr           = 1'b1;
        end
        frfpo_pkg::REG_POINT: begin
          cfg_nxt.point_mode = pwdata[frfpo_pkg::PT_W-1:0];
        end
        frfpo_pkg::REG_BRIGHTNESS: begin
          cfg_nxt.brightness_offset = $signed(pwdata[frfpo_pkg::OFF_W-1:0]);
        end
        frfpo_pkg::REG_WIDTH: begin
          cfg_nxt.image_width = pwdata[frfpo_pkg::DIM_W-1:0];
          evt.dim_wr          = 1'b1;
        end
        frfpo_pkg::REG_HEIGHT: begin
          cfg_nxt.image_height = pwdata[frfpo_pkg::DIM_W-1:0];
          evt.dim_wr           = 1'b1;
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.geometry_mode     <= frfpo_pkg::GEO_IDENT;
      cfg_r.point_mode        <= frfpo_pkg::PT_NONE;
      cfg_r.brightness_offset <= '0;
      cfg_r.image_width       <= frfpo_pkg::DIM_RESET;
      cfg_r.image_height      <= frfpo_pkg::DIM_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    unique case (idx)
      frfpo_pkg::REG_GEOMETRY:   prdata = frfpo_pkg::DATA_W'(cfg_r.geometry_mode);
      frfpo_pkg::REG_POINT:      prdata = frfpo_pkg::DATA_W'(cfg_r.point_mode);
      frfpo_pkg::REG_BRIGHTNESS: prdata = frfpo_pkg::DATA_W'(cfg_r.brightness_offset);
      frfpo_pkg::REG_WIDTH:      prdata = frfpo_pkg::DATA_W'(cfg_r.image_width);
      frfpo_pkg::REG_HEIGHT:     prdata = frfpo_pkg::DATA_W'(cfg_r.image_height);
      default:                   prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

### src/frfpo_seq.sv
module frfpo_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  frfpo_pkg::in_item_t   item,
  input  frfpo_pkg::cfg_t       cfg,
  input  frfpo_pkg::cfg_evt_t   evt,
  output frfpo_pkg::mem_req_t   mem_req,
  output frfpo_pkg::tag_t       tag
);

  logic [frfpo_pkg::POS_W-1:0]  row_r, row_nxt;
  logic [frfpo_pkg::POS_W-1:0]  col_r, col_nxt;
  logic [frfpo_pkg::CNT_W-1:0]  load_count_r, load_count_nxt;
  logic                         frame_full_r, frame_full_nxt;

  logic [frfpo_pkg::DIM_W-1:0]  w, h, ow, oh, wm1, hm1;
  logic [frfpo_pkg::DIM_W-1:0]  row9, col9, row_i, col_i, sy9, sx9;
  logic [frfpo_pkg::GEO_W-1:0]  geo;
  logic                         swap, in_range, eor, last_row;
  logic [frfpo_pkg::PROD_W-1:0] prod, raddr_sum;
  logic [frfpo_pkg::AREA_W-1:0] area;
  logic [frfpo_pkg::CNT_W-1:0]  base, cnt_inc;
  logic                         is_load, is_fetch;

  always_comb begin
    w    = frfpo_pkg::eff_dim(cfg.image_width, frfpo_pkg::MAX_WIDTH);
    h    = frfpo_pkg::eff_dim(cfg.image_height, frfpo_pkg::MAX_HEIGHT);
    wm1  = w - frfpo_pkg::DIM_W'(1);
    hm1  = h - frfpo_pkg::DIM_W'(1);
    geo  = (cfg.geometry_mode > frfpo_pkg::GEO_MIRROR) ? frfpo_pkg::GEO_IDENT
                                                        : cfg.geometry_mode;
    swap = (geo == frfpo_pkg::GEO_ROT90) || (geo == frfpo_pkg::GEO_ROT270);
    ow   = swap ? h : w;
    oh   = swap ? w : h;

    row9     = frfpo_pkg::DIM_W'(row_r);
    col9     = frfpo_pkg::DIM_W'(col_r);
    in_range = (row9 < oh) && (col9 < ow);
    row_i    = in_range ? row9 : '0;
    col_i    = in_range ? col9 : '0;

    // Source coordinate in the loaded frame for the current output position.
    case (geo)
      frfpo_pkg::GEO_ROT90: begin
        sy9 = hm1 - col_i;
        sx9 = row_i;
      end
      frfpo_pkg::GEO_ROT180: begin
        sy9 = hm1 - row_i;
        sx9 = wm1 - col_i;
      end
      frfpo_pkg::GEO_ROT270: begin
        sy9 = col_i;
        sx9 = wm1 - row_i;
      end
      frfpo_pkg::GEO_MIRROR: begin
        sy9 = row_i;
        sx9 = wm1 - col_i;
      end
      default: begin
        sy9 = row_i;
        sx9 = col_i;
      end
    endcase

    prod      = frfpo_pkg::PROD_W'(sy9[frfpo_pkg::POS_W-1:0]) * frfpo_pkg::PROD_W'(w);
    raddr_sum = prod + frfpo_pkg::PROD_W'(sx9[frfpo_pkg::POS_W-1:0]);

    eor      = (col_i == ow - frfpo_pkg::DIM_W'(1));
    last_row = (row_i == oh - frfpo_pkg::DIM_W'(1));

    area    = frfpo_pkg::AREA_W'(w) * frfpo_pkg::AREA_W'(h);
    base    = frame_full_r ? '0 : load_count_r;
    cnt_inc = base + frfpo_pkg::CNT_W'(1);

    is_load  = accept && (item.action == frfpo_pkg::ACT_LOAD);
    is_fetch = accept && (item.action == frfpo_pkg::ACT_FETCH);

    mem_req.we    = is_load && (base < frfpo_pkg::CNT_W'(frfpo_pkg::STORE_DEPTH));
    mem_req.waddr = base[frfpo_pkg::ADDR_W-1:0];
    mem_req.wdata = {item.red_in, item.green_in, item.blue_in};
    mem_req.re    = is_fetch && frame_full_r;
    mem_req.raddr = raddr_sum[frfpo_pkg::ADDR_W-1:0];

    tag.not_ready    = !frame_full_r;
    tag.end_of_row   = frame_full_r && eor;
    tag.end_of_frame = frame_full_r && eor && last_row;
  end

  always_comb begin
    row_nxt        = row_r;
    col_nxt        = col_r;
    load_count_nxt = load_count_r;
    frame_full_nxt = frame_full_r;
    if (evt.dim_wr) begin
      row_nxt        = '0;
      col_nxt        = '0;
      load_count_nxt = '0;
      frame_full_nxt = 1'b0;
    end else if (evt.geom_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (is_load) begin
      // A load into a full frame starts a new one.
      if (frame_full_r) begin
        row_nxt = '0;
        col_nxt = '0;
      end
      load_count_nxt = cnt_inc;
      frame_full_nxt = (frfpo_pkg::AREA_W'(cnt_inc) >= area);
    end else if (is_fetch && frame_full_r) begin
      if (eor) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : frfpo_pkg::POS_W'(row_i + frfpo_pkg::DIM_W'(1));
      end else begin
        row_nxt = row_i[frfpo_pkg::POS_W-1:0];
        col_nxt = frfpo_pkg::POS_W'(col_i + frfpo_pkg::DIM_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      col_r        <= '0;
      load_count_r <= '0;
      frame_full_r <= 1'b0;
    end else begin
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      load_count_r <= load_count_nxt;
      frame_full_r <= frame_full_nxt;
    end
  end

endmodule

### src/frfpo_frame_store.sv
module frfpo_frame_store (
  input  logic                         clk,
  input  frfpo_pkg::mem_req_t          mem_req,
  output logic [frfpo_pkg::PIX_W-1:0]  rd_data
);

  logic [frfpo_pkg::PIX_W-1:0] mem [frfpo_pkg::STORE_DEPTH];
  logic [frfpo_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Read data holds until the next read, which keeps it valid under stall.
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### src/frfpo_pixel_op.sv
module frfpo_pixel_op (
  input  logic [frfpo_pkg::PIX_W-1:0]  pix,
  input  frfpo_pkg::tag_t              tag,
  input  frfpo_pkg::cfg_t              cfg,
  output frfpo_pkg::out_item_t         item
);

  logic [frfpo_pkg::CH_W-1:0]  r, g, b, gray;
  logic [frfpo_pkg::SUM_W-1:0] sum;

  function automatic logic [frfpo_pkg::CH_W-1:0] chan_op(
    input logic [frfpo_pkg::CH_W-1:0]         c,
    input logic [frfpo_pkg::CH_W-1:0]         gr,
    input logic [frfpo_pkg::PT_W-1:0]         mode,
    input logic signed [frfpo_pkg::OFF_W-1:0] off
  );
    logic signed [frfpo_pkg::BV_W-1:0] v;
    logic [frfpo_pkg::CH_W-1:0]        res;
    v = $signed(frfpo_pkg::BV_W'(c)) + frfpo_pkg::BV_W'(off);
    case (mode)
      frfpo_pkg::PT_GRAY:   res = gr;
      frfpo_pkg::PT_INVERT: res = frfpo_pkg::CH_MAX - c;
      frfpo_pkg::PT_BRIGHT: begin
        if (v < 0) begin
          res = '0;
        end else if (v > $signed(frfpo_pkg::BV_W'(frfpo_pkg::CH_MAX))) begin
          res = frfpo_pkg::CH_MAX;
        end else begin
          res = v[frfpo_pkg::CH_W-1:0];
        end
      end
      default:              res = c;
    endcase
    return res;
  endfunction

  always_comb begin
    r    = pix[2*frfpo_pkg::CH_W +: frfpo_pkg::CH_W];
    g    = pix[frfpo_pkg::CH_W +: frfpo_pkg::CH_W];
    b    = pix[0 +: frfpo_pkg::CH_W];
    sum  = frfpo_pkg::SUM_W'(r) + frfpo_pkg::SUM_W'(g) + frfpo_pkg::SUM_W'(b);
    gray = frfpo_pkg::div3(sum);

    if (tag.not_ready) begin
      item.red_out   = '0;
      item.green_out = '0;
      item.blue_out  = '0;
    end else begin
      item.red_out   = chan_op(r, gray, cfg.point_mode, cfg.brightness_offset);
      item.green_out = chan_op(g, gray, cfg.point_mode, cfg.brightness_offset);
      item.blue_out  = chan_op(b, gray, cfg.point_mode, cfg.brightness_offset);
    end
    item.end_of_row   = tag.end_of_row;
    item.end_of_frame = tag.end_of_frame;
    item.not_ready    = tag.not_ready;
  end

endmodule

### src/frame_rotate_flip_point_ops.sv
// Frame engine: loads an RGB frame in raster order and reads it back rotated or
// mirrored, with a per-pixel point operation on the way out.
// Input channel (in_valid, in_stall, in_data): a load beat stores one pixel, a fetch
// beat returns one pixel of the transformed frame. Loads give no output beat.
// Output channel (out_valid, out_stall, out_data): one beat per fetch, in order.
// A fetch before the whole frame is loaded returns a beat flagged not_ready.
// Registers are written over the APB-style port; the user must do so only while the
// block is idle, as the block itself does not enforce it. A fetch passes through the
// read data and flag registers, then the output register. Throughput: one beat per
// cycle unless out_stall holds the pipeline, set by the single frame store access
// each beat makes at its accept edge (a write for loads, a read for fetches).
// Reset clears the pipeline, the load count and the readout position; the frame
// store is not cleared, so there is no clearing pass and no wait after reset.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_stall goes high until the output beat is taken.
`include "frame_rotate_flip_point_ops_defines.svh"

module frame_rotate_flip_point_ops (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  frfpo_pkg::in_item_t            in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output frfpo_pkg::out_item_t           out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [frfpo_pkg::PADDR_W-1:0]  paddr,
  input  logic [frfpo_pkg::DATA_W-1:0]   pwdata,
  output logic [frfpo_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  frfpo_pkg::cfg_t             cfg;
  frfpo_pkg::cfg_evt_t         evt;
  frfpo_pkg::mem_req_t         mem_req;
  frfpo_pkg::tag_t             tag;
  frfpo_pkg::tag_t             st1_tag_r;
  frfpo_pkg::out_item_t        pix_item;
  frfpo_pkg::out_item_t        out_data_r;
  logic [frfpo_pkg::PIX_W-1:0] rd_data;
  logic                        st1_valid_r;
  logic                        out_valid_r;
  logic                        advance;
  logic                        accept;
  logic                        is_fetch;

  // The pipeline moves whenever the output register is empty or being drained.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign is_fetch = (in_data.action == frfpo_pkg::ACT_FETCH);

  frfpo_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .evt     (evt)
  );

  // Address generation and frame bookkeeping; the store access happens at the
  // accept edge so loads and fetches hit the memory in arrival order.
  frfpo_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .item    (in_data),
    .cfg     (cfg),
    .evt     (evt),
    .mem_req (mem_req),
    .tag     (tag)
  );

  frfpo_frame_store u_store (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  // First stage: the fetch's flags travel alongside the registered read data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_valid_r <= 1'b0;
    end else if (advance) begin
      st1_valid_r <= accept && is_fetch;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st1_tag_r <= tag;
    end
  end

  // Point operation between the read data register and the output register.
  frfpo_pixel_op u_pix (
    .pix  (rd_data),
    .tag  (st1_tag_r),
    .cfg  (cfg),
    .item (pix_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= st1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= pix_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `FRFPO_ASSERT(a_stall_only_on_full_output, clk, rst_n, in_stall |-> (out_valid && out_stall))
  `FRFPO_ASSERT(a_fetch_enters_pipe, clk, rst_n, (in_valid && !in_stall && is_fetch) |=> st1_valid_r)
  `FRFPO_ASSERT(a_stage_feeds_output, clk, rst_n, (st1_valid_r && !in_stall) |=> out_valid)
  `FRFPO_ASSERT_NORST(a_reset_empties_pipe, clk, (!rst_n) |=> (!out_valid && !st1_valid_r))

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import frfpo_pkg::*;

  // Clock, drain and watchdog figures. A fetch reaches the result side through the
  // read data and output registers, and a load writes the frame store at the edge
  // that takes it, so the settle pause after the last result is enough for any load.
  localparam int CLK_HALF      = 6;
  localparam int SETTLE_CYCLES = 4;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1000;
  localparam int REPORT_MAX    = 10;

  // An index with no register behind it, and a geometry code with no meaning.
  localparam logic [IDX_W-1:0] REG_SPARE  = 3'd7;
  localparam logic [GEO_W-1:0] GEO_UNUSED = 3'd7;

  typedef logic [IDX_W-1:0] reg_idx_t;

  // One line of the directed script: either a register write or an input beat.
  // Where the outcome is obvious, the expected result beat is written out.
  typedef struct packed {
    logic             is_write;
    reg_idx_t         reg_idx;
    logic [DIM_W-1:0] value;
    in_item_t         beat;
    logic             typed;
    out_item_t        golden;
  } script_row_t;

  // Travels beside each input beat so that the monitor knows whether to use the
  // written-out result instead of the shadow model's.
  typedef struct packed {
    logic      typed;
    out_item_t golden;
  } beat_note_t;

  logic               clk;
  logic               rst_n   = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_item_t          out_data;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0]  pwdata  = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  // Idle control: a calm side never pauses, so some stretches run at full rate.
  logic in_calm  = 1'b0;
  logic out_calm = 1'b0;

  // Shadow copy of the frame engine: store, fill count, readout position and
  // the register values, all updated at the edges where the block takes them.
  logic [PIX_W-1:0]        shadow_store [STORE_DEPTH];
  int unsigned             shadow_fill;
  int unsigned             shadow_row;
  int unsigned             shadow_col;
  logic                    shadow_full;
  logic [GEO_W-1:0]        geo_sel;
  logic [PT_W-1:0]         pt_sel;
  logic signed [OFF_W-1:0] offset_sel;
  logic [DIM_W-1:0]        width_sel;
  logic [DIM_W-1:0]        height_sel;

  out_item_t  pixels_due [$];
  beat_note_t beat_notes [$];

  int unsigned faults;
  int unsigned beats_sent;
  int unsigned random_beats;
  int unsigned results_seen;
  int unsigned frames_closed;
  int unsigned refusals;
  int unsigned writes_done;
  int unsigned settings_run;
  int unsigned quiet;

  frame_rotate_flip_point_ops dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // A zero dimension counts as one, an oversized one as the store limit.
  function automatic int unsigned span(logic [DIM_W-1:0] v, int unsigned limit);
    if (v == '0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  // Point operation on one channel, using the live point mode and offset.
  function automatic logic [CH_W-1:0] shade(logic [CH_W-1:0] c, logic [CH_W-1:0] gray);
    int v;
    v = int'(c) + int'(offset_sel);
    case (pt_sel)
      PT_GRAY:   return gray;
      PT_INVERT: return CH_MAX - c;
      PT_BRIGHT: begin
        if (v < 0) v = 0;
        else if (v > int'(CH_MAX)) v = int'(CH_MAX);
        return CH_W'(v);
      end
      default:   return c;
    endcase
  endfunction

  // Register write as seen by the shadow model. Geometry writes restart the
  // readout, dimension writes throw the loaded frame away.
  task automatic apply_register(reg_idx_t idx, logic [DATA_W-1:0] data);
    case (idx)
      REG_GEOMETRY: begin
        geo_sel    = data[GEO_W-1:0];
        shadow_row = 0;
        shadow_col = 0;
      end
      REG_POINT:      pt_sel     = data[PT_W-1:0];
      REG_BRIGHTNESS: offset_sel = data[OFF_W-1:0];
      REG_WIDTH, REG_HEIGHT: begin
        if (idx == REG_WIDTH) width_sel = data[DIM_W-1:0];
        else height_sel = data[DIM_W-1:0];
        shadow_fill = 0;
        shadow_full = 1'b0;
        shadow_row  = 0;
        shadow_col  = 0;
      end
      default: ;
    endcase
  endtask

  // One input beat through the shadow model. A load stores a pixel and gives
  // nothing back; a fetch gives one result beat.
  task automatic advance_frame(input in_item_t b, output logic emits, output out_item_t res);
    int unsigned      w, h, ow, oh, sx, sy;
    logic [GEO_W-1:0] g;
    logic [PIX_W-1:0] pix;
    logic [CH_W-1:0]  r, gr, bl, gray;
    w     = span(width_sel, MAX_WIDTH);
    h     = span(height_sel, MAX_HEIGHT);
    res   = '0;
    emits = 1'b1;
    if (b.action == ACT_LOAD) begin
      // A load after a complete frame starts the next one from the top.
      if (shadow_full) begin
        shadow_fill = 0;
        shadow_full = 1'b0;
        shadow_row  = 0;
        shadow_col  = 0;
      end
      if (shadow_fill < STORE_DEPTH) shadow_store[shadow_fill] = {b.red_in, b.green_in, b.blue_in};
      shadow_fill++;
      if (shadow_fill >= w * h) shadow_full = 1'b1;
      emits = 1'b0;
    end else if (!shadow_full) begin
      res.not_ready = 1'b1;
    end else begin
      g = (geo_sel > GEO_MIRROR) ? GEO_IDENT : geo_sel;
      if (g == GEO_ROT90 || g == GEO_ROT270) begin
        ow = h;
        oh = w;
      end else begin
        ow = w;
        oh = h;
      end
      if (shadow_row >= oh || shadow_col >= ow) begin
        shadow_row = 0;
        shadow_col = 0;
      end
      case (g)
        GEO_ROT90: begin
          sy = h - 1 - shadow_col;
          sx = shadow_row;
        end
        GEO_ROT180: begin
          sy = h - 1 - shadow_row;
          sx = w - 1 - shadow_col;
        end
        GEO_ROT270: begin
          sy = shadow_col;
          sx = w - 1 - shadow_row;
        end
        GEO_MIRROR: begin
          sy = shadow_row;
          sx = w - 1 - shadow_col;
        end
        default: begin
          sy = shadow_row;
          sx = shadow_col;
        end
      endcase
      pix          = shadow_store[(sy * w + sx) % STORE_DEPTH];
      {r, gr, bl}  = pix;
      gray         = CH_W'((int'(r) + int'(gr) + int'(bl)) / 3);
      res.red_out      = shade(r, gray);
      res.green_out    = shade(gr, gray);
      res.blue_out     = shade(bl, gray);
      res.end_of_row   = (shadow_col == ow - 1);
      res.end_of_frame = (shadow_col == ow - 1) && (shadow_row == oh - 1);
      shadow_col++;
      if (shadow_col >= ow) begin
        shadow_col = 0;
        shadow_row++;
        if (shadow_row >= oh) shadow_row = 0;
      end
    end
  endtask

  function automatic out_item_t pix_result(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                           logic [CH_W-1:0] b, logic eor, logic eof,
                                           logic refused);
    out_item_t res;
    res.red_out      = r;
    res.green_out    = g;
    res.blue_out     = b;
    res.end_of_row   = eor;
    res.end_of_frame = eof;
    res.not_ready    = refused;
    return res;
  endfunction

  function automatic script_row_t cfg_row(reg_idx_t idx, logic [DIM_W-1:0] value);
    script_row_t row;
    row          = '0;
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.value    = value;
    return row;
  endfunction

  function automatic script_row_t load_row(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                           logic [CH_W-1:0] b);
    script_row_t row;
    row              = '0;
    row.beat.action   = ACT_LOAD;
    row.beat.red_in   = r;
    row.beat.green_in = g;
    row.beat.blue_in  = b;
    return row;
  endfunction

  function automatic script_row_t fetch_row(logic typed, out_item_t golden);
    script_row_t row;
    row             = '0;
    row.beat.action = ACT_FETCH;
    row.typed       = typed;
    row.golden      = golden;
    return row;
  endfunction

  // Channel values lean toward the ends of the range now and then, so the
  // clamp and inversion corners come up often.
  function automatic logic [CH_W-1:0] channel();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? CH_MAX : '0;
    return CH_W'($urandom);
  endfunction

  // Fetch beats carry random channel bits too; the block must ignore them.
  function automatic in_item_t random_beat(logic action);
    in_item_t b;
    b.action   = action;
    b.red_in   = channel();
    b.green_in = channel();
    b.blue_in  = channel();
    return b;
  endfunction

  function automatic logic [DIM_W-1:0] oversize();
    if ($urandom_range(0, 2) == 0) return DIM_RESET;
    return DIM_W'($urandom_range(MAX_WIDTH + 1, 511));
  endfunction

  // Offers one input beat after a random pause and returns at the edge that
  // takes it. in_valid stays high so back-to-back beats need no extra cycle.
  task automatic push_beat(in_item_t b, logic typed, out_item_t golden);
    int unsigned gap;
    beat_note_t  note;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    note.typed  = typed;
    note.golden = golden;
    beat_notes.push_back(note);
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Waits until every fetch has returned its beat, then a little longer so
  // that trailing loads are through the pipeline before a register changes.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup and access phase, then an idle phase with psel low so writes never overlap.
  task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    writes_done++;
  endtask

  // One random setting followed by a frame's worth of traffic. Most of it is a
  // clean load then one or two full readouts; a few fetches land before the
  // frame is complete and a stray load sometimes cuts a readout short. Phase 3
  // uses the widest frame the store allows and phase 7 the tallest.
  task automatic random_phase(int unsigned phase_no);
    logic [DIM_W-1:0] w_raw, h_raw;
    logic [OFF_W-1:0] offset;
    int unsigned      area, n_fetch, i;
    logic             new_dims;
    in_item_t         batch [$];
    in_calm  = ($urandom_range(0, 3) == 0);
    out_calm = ($urandom_range(0, 3) == 0);
    new_dims = 1'b1;
    if (phase_no == 3) begin
      w_raw = oversize();
      h_raw = DIM_W'($urandom_range(0, 1));
    end else if (phase_no == 7) begin
      w_raw = DIM_W'($urandom_range(0, 1));
      h_raw = oversize();
    end else if (shadow_full && $urandom_range(0, 2) == 0) begin
      // Keep the loaded frame and read it back under new settings.
      new_dims = 1'b0;
      w_raw    = width_sel;
      h_raw    = height_sel;
    end else begin
      w_raw = DIM_W'($urandom_range(0, 5));
      h_raw = DIM_W'($urandom_range(0, 5));
    end
    area = span(w_raw, MAX_WIDTH) * span(h_raw, MAX_HEIGHT);

    settle();
    if (new_dims) begin
      write_reg(REG_WIDTH, DATA_W'(w_raw));
      write_reg(REG_HEIGHT, DATA_W'(h_raw));
    end
    if (!new_dims || $urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 5) == 0) write_reg(REG_GEOMETRY, $urandom_range(5, 7));
      else write_reg(REG_GEOMETRY, $urandom_range(0, 4));
    end
    write_reg(REG_POINT, $urandom_range(0, 3));
    case ($urandom_range(0, 4))
      0:       offset = 9'h101;
      1:       offset = 9'h0FF;
      2:       offset = 9'h100;
      default: offset = OFF_W'($urandom);
    endcase
    write_reg(REG_BRIGHTNESS, DATA_W'(offset));
    if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, $urandom);
    settings_run++;

    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) batch.push_back(random_beat(ACT_FETCH));
    end
    if (new_dims || $urandom_range(0, 1) == 0) begin
      for (i = 0; i < area; i++) begin
        batch.push_back(random_beat(ACT_LOAD));
        if (area <= 64 && $urandom_range(0, 15) == 0) batch.push_back(random_beat(ACT_FETCH));
      end
    end
    n_fetch = (area > 64) ? area + 1 : area * $urandom_range(1, 2) + $urandom_range(0, 3);
    repeat (n_fetch) batch.push_back(random_beat(ACT_FETCH));
    if (area <= 64 && $urandom_range(0, 5) == 0) begin
      batch.push_back(random_beat(ACT_LOAD));
      repeat (2) batch.push_back(random_beat(ACT_FETCH));
    end
    foreach (batch[k]) push_beat(batch[k], 1'b0, '0);
    random_beats += batch.size();
  endtask

  // Scoreboard. Result beats are checked first, then register writes and input
  // beats update the shadow model, all with the values seen before this edge.
  always @(posedge clk) begin : monitor
    out_item_t  want;
    out_item_t  pred;
    logic       emits;
    beat_note_t note;
    if (!rst_n) begin
      geo_sel     = GEO_IDENT;
      pt_sel      = PT_NONE;
      offset_sel  = '0;
      width_sel   = DIM_RESET;
      height_sel  = DIM_RESET;
      shadow_fill = 0;
      shadow_full = 1'b0;
      shadow_row  = 0;
      shadow_col  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_data.end_of_frame) frames_closed++;
        if (out_data.not_ready) refusals++;
        if (pixels_due.size() == 0) begin
          faults++;
          if (faults <= REPORT_MAX) begin
            $display("[%0t] result beat with nothing outstanding: rgb %0d/%0d/%0d eor %b eof %b nr %b",
                     $time, out_data.red_out, out_data.green_out, out_data.blue_out,
                     out_data.end_of_row, out_data.end_of_frame, out_data.not_ready);
          end
        end else begin
          want = pixels_due.pop_front();
          if (out_data !== want) begin
            faults++;
            if (faults <= REPORT_MAX) begin
              $display("[%0t] wrong pixel: expected rgb %0d/%0d/%0d eor %b eof %b nr %b", $time,
                       want.red_out, want.green_out, want.blue_out,
                       want.end_of_row, want.end_of_frame, want.not_ready);
              $display("                  got      rgb %0d/%0d/%0d eor %b eof %b nr %b",
                       out_data.red_out, out_data.green_out, out_data.blue_out,
                       out_data.end_of_row, out_data.end_of_frame, out_data.not_ready);
            end
          end
        end
      end
      if (psel && penable && pwrite && pready) apply_register(paddr[PADDR_W-1:2], pwdata);
      if (in_valid && !in_stall) begin
        note = beat_notes.pop_front();
        advance_frame(in_data, emits, pred);
        if (emits) pixels_due.push_back(note.typed ? note.golden : pred);
      end
    end
  end

  // Result side back-pressure: before each result beat the receiver holds off
  // for a random number of cycles, unless the phase runs calm.
  initial begin : receiver
    int unsigned hold;
    wait (rst_n);
    @(posedge clk);
    forever begin
      hold = out_calm ? 0 : $urandom_range(0, 7);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Watchdog: any beat, on either channel or the register port, counts as
  // progress. A long run of cycles without one means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("[%0t] no progress for %0d cycles, %0d result beats outstanding",
               $time, QUIET_LIMIT, pixels_due.size());
      $display("frame_rotate_flip_point_ops: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    script_row_t script [$];
    int unsigned phase_no;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script. It opens on the reset frame size with nothing loaded,
    // shrinks the frame to one pixel through zero dimensions, walks every point
    // operation including both clamp ends and the most negative offset, writes
    // an index that has no register, then rotates a small non-square frame and
    // finishes on a geometry code that must act as identity.
    script = '{
      fetch_row(1'b1, pix_result(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1)),
      cfg_row(REG_WIDTH, 9'd0),
      cfg_row(REG_HEIGHT, 9'd0),
      fetch_row(1'b1, pix_result(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1)),
      load_row(8'd255, 8'd255, 8'd255),
      fetch_row(1'b1, pix_result(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0)),
      fetch_row(1'b1, pix_result(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0)),
      cfg_row(REG_POINT, DIM_W'(PT_INVERT)),
      cfg_row(REG_SPARE, 9'h1FF),
      fetch_row(1'b1, pix_result(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0)),
      load_row(8'd0, 8'd0, 8'd0),
      fetch_row(1'b1, pix_result(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0)),
      cfg_row(REG_POINT, DIM_W'(PT_BRIGHT)),
      cfg_row(REG_BRIGHTNESS, 9'h0FF),
      fetch_row(1'b1, pix_result(8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b0)),
      load_row(8'd255, 8'd128, 8'd1),
      cfg_row(REG_BRIGHTNESS, 9'h100),
      fetch_row(1'b1, pix_result(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0)),
      cfg_row(REG_BRIGHTNESS, 9'h101),
      fetch_row(1'b1, pix_result(8'd0, 8'd0, 8'd0, 1'b1, 1'b1, 1'b0)),
      cfg_row(REG_POINT, DIM_W'(PT_GRAY)),
      fetch_row(1'b1, pix_result(8'd128, 8'd128, 8'd128, 1'b1, 1'b1, 1'b0)),
      cfg_row(REG_POINT, DIM_W'(PT_NONE)),
      cfg_row(REG_WIDTH, 9'd3),
      cfg_row(REG_HEIGHT, 9'd2),
      cfg_row(REG_GEOMETRY, DIM_W'(GEO_ROT90)),
      load_row(8'h01, 8'h02, 8'h04),
      load_row(8'h08, 8'h10, 8'h20),
      load_row(8'h40, 8'h80, 8'hAA),
      load_row(8'h55, 8'h0F, 8'hF0),
      load_row(8'h33, 8'hCC, 8'h99),
      load_row(8'h66, 8'h3C, 8'hC3),
      fetch_row(1'b0, '0),
      fetch_row(1'b0, '0),
      fetch_row(1'b0, '0),
      cfg_row(REG_GEOMETRY, DIM_W'(GEO_UNUSED)),
      fetch_row(1'b0, '0),
      fetch_row(1'b0, '0)
    };
    foreach (script[i]) begin
      if (script[i].is_write) begin
        settle();
        write_reg(script[i].reg_idx, DATA_W'(script[i].value));
      end else begin
        push_beat(script[i].beat, script[i].typed, script[i].golden);
      end
    end

    // Random phases until enough beats have gone in.
    phase_no = 0;
    while (random_beats < RANDOM_ITEMS) begin
      random_phase(phase_no);
      phase_no++;
    end
    settle();

    $display("Sent %0d input beats over %0d random settings with %0d register writes.",
             beats_sent, settings_run, writes_done);
    $display("Checked %0d result beats: %0d complete frames read out, %0d early fetches refused.",
             results_seen, frames_closed, refusals);
    if (faults == 0 && pixels_due.size() == 0) begin
      $display("frame_rotate_flip_point_ops: match");
    end else begin
      $display("frame_rotate_flip_point_ops: mismatch");
    end
    $finish;
  end

endmodule
